FILE: rtl/resource_deadlock_detector_top_defines.svh
// Assertion macros used by the resource deadlock detector checker
`ifndef RESOURCE_DEADLOCK_DETECTOR_TOP_DEFINES_SVH
`define RESOURCE_DEADLOCK_DETECTOR_TOP_DEFINES_SVH

// Check a consequent in the same cycle as its antecedent
`define RDD_ASSERT_SAME(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define RDD_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/rdd_pkg.sv
// Package: shared types, codes and defaults of the resource deadlock detector
`timescale 1ns / 1ps

package rdd_pkg;

    // Default sizes of the tables
    localparam int MAX_PROCESSES_DEF      = 16;
    localparam int MAX_RESOURCE_TYPES_DEF = 8;
    localparam int AMOUNT_WIDTH_DEF       = 16;
    localparam int WORK_WIDTH_DEF         = 22;

    // Fixed field widths of the channels
    localparam int PROC_IDX_W  = 4;
    localparam int RES_IDX_W   = 3;
    localparam int AMOUNT_W    = 16;
    localparam int ACT_PROC_W  = 5;
    localparam int ACT_RES_W   = 4;
    localparam int CFG_DATA_W  = 5;

    // Register reset values
    localparam logic [ACT_PROC_W-1:0] ACT_PROC_RESET = 5'd16;
    localparam logic [ACT_RES_W-1:0]  ACT_RES_RESET  = 4'd8;

    typedef enum logic [1:0] {
        CMD_LOAD_EXISTING   = 2'd0,
        CMD_LOAD_ALLOCATION = 2'd1,
        CMD_LOAD_REQUEST    = 2'd2,
        CMD_RUN             = 2'd3
    } rdd_cmd_t;

    typedef enum logic [0:0] {
        CFG_ACTIVE_PROCESSES      = 1'b0,
        CFG_ACTIVE_RESOURCE_TYPES = 1'b1
    } rdd_cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SUM_RD,
        ST_SUM_EX,
        ST_SCAN,
        ST_CHK_RD,
        ST_CHK_EX,
        ST_ADD_RD,
        ST_ADD_EX,
        ST_EMIT,
        ST_EMPTY
    } rdd_state_t;

    // Accepted input item handed to the core
    typedef struct packed {
        logic                  valid;
        rdd_cmd_t              command;
        logic [PROC_IDX_W-1:0] process_index;
        logic [RES_IDX_W-1:0]  resource_index;
        logic [AMOUNT_W-1:0]   amount;
    } rdd_load_t;

    // One result item
    typedef struct packed {
        logic [PROC_IDX_W-1:0] deadlocked_process;
        logic                  is_last;
        logic                  none_deadlocked;
    } rdd_result_t;

endpackage

FILE: rtl/rdd_if.sv
// Interfaces: item, result and configuration channels
`timescale 1ns / 1ps

interface rdd_item_if;
    import rdd_pkg::*;

    logic                  valid;
    logic                  ready;
    rdd_cmd_t              command;
    logic [PROC_IDX_W-1:0] process_index;
    logic [RES_IDX_W-1:0]  resource_index;
    logic [AMOUNT_W-1:0]   amount;

    modport source (output valid, command, process_index, resource_index, amount,
                    input ready);
    modport sink   (input valid, command, process_index, resource_index, amount,
                    output ready);
endinterface

interface rdd_result_if;
    import rdd_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [PROC_IDX_W-1:0] deadlocked_process;
    logic                  is_last;
    logic                  none_deadlocked;

    modport source (output valid, deadlocked_process, is_last, none_deadlocked,
                    input ready);
    modport sink   (input valid, deadlocked_process, is_last, none_deadlocked,
                    output ready);
endinterface

interface rdd_cfg_if;
    import rdd_pkg::*;

    logic                  valid;
    logic                  ready;
    rdd_cfg_idx_t          index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/rdd_alu.sv
// Shared add/subtract unit used for column sums, request checks and work updates
`timescale 1ns / 1ps

module rdd_alu #(
    parameter int WIDTH = rdd_pkg::WORK_WIDTH_DEF
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  logic             sub,
    output logic [WIDTH-1:0] sum,
    output logic             negative
);
    // Add, or subtract via inverted operand and carry in
    assign sum      = a + (b ^ {WIDTH{sub}}) + WIDTH'(sub);
    assign negative = sum[WIDTH-1];
endmodule

FILE: rtl/rdd_core.sv
// Core: tables, work vector, finished flags and the detection sequencer
`timescale 1ns / 1ps

module rdd_core #(
    parameter int MAX_PROCESSES      = rdd_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCE_TYPES = rdd_pkg::MAX_RESOURCE_TYPES_DEF,
    parameter int AMOUNT_WIDTH       = rdd_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [rdd_pkg::ACT_PROC_W-1:0]  active_processes,
    input  logic [rdd_pkg::ACT_RES_W-1:0]   active_resource_types,
    input  rdd_pkg::rdd_load_t              load,
    output logic                            idle,
    output rdd_pkg::rdd_result_t            res,
    output logic                            res_valid,
    input  logic                            res_ready
);
    import rdd_pkg::*;

    localparam int PW     = $clog2(MAX_PROCESSES);
    localparam int RW     = (MAX_RESOURCE_TYPES > 1) ? $clog2(MAX_RESOURCE_TYPES) : 1;
    localparam int NPW    = $clog2(MAX_PROCESSES + 1);
    localparam int NRW    = $clog2(MAX_RESOURCE_TYPES + 1);
    localparam int AW     = PW + RW;
    localparam int DEPTH  = MAX_PROCESSES << RW;
    localparam int EDEPTH = 1 << RW;
    localparam int WW     = AMOUNT_WIDTH + PW + 2;

    // Tables
    logic [AMOUNT_WIDTH-1:0] alloc_mem [DEPTH];
    logic [AMOUNT_WIDTH-1:0] req_mem   [DEPTH];
    logic [AMOUNT_WIDTH-1:0] exist_mem [EDEPTH];
    logic [AMOUNT_WIDTH-1:0] alloc_q;
    logic [AMOUNT_WIDTH-1:0] req_q;
    logic [AMOUNT_WIDTH-1:0] ext_q;

    // Sequencer state
    rdd_state_t              state_reg, state_next;
    logic [PW-1:0]           p_reg, p_next;
    logic [RW-1:0]           r_reg, r_next;
    logic [WW-1:0]           acc_reg, acc_next;
    logic                    progress_reg, progress_next;
    logic [MAX_PROCESSES-1:0] finished_reg, finished_next;
    logic [WW-1:0]           work_reg [EDEPTH];
    logic [WW-1:0]           work_next;
    logic                    work_we;

    logic [AMOUNT_WIDTH-1:0] load_amount;
    logic                    res_ok;
    logic                    proc_ok;
    logic [AW-1:0]           wr_addr;
    logic [AW-1:0]           rd_addr;
    logic [NPW-1:0]          np;
    logic [NRW-1:0]          nr;
    logic                    p_last;
    logic                    r_last;
    logic                    proc_done;
    logic [MAX_PROCESSES-1:0] emit_mask;
    logic [WW-1:0]           work_rd;
    logic [WW-1:0]           alu_a;
    logic [WW-1:0]           alu_b;
    logic                    alu_sub;
    logic [WW-1:0]           alu_sum;
    logic                    alu_neg;

    // Decode the load target
    assign load_amount = AMOUNT_WIDTH'(load.amount);
    assign res_ok      = 32'(load.resource_index) < 32'(MAX_RESOURCE_TYPES);
    assign proc_ok     = 32'(load.process_index) < 32'(MAX_PROCESSES);
    assign wr_addr     = {PW'(load.process_index), RW'(load.resource_index)};
    assign rd_addr     = {p_reg, r_reg};

    // Write and read the allocation table
    always_ff @(posedge clk)
    begin
        if (load.valid && res_ok && proc_ok && load.command == CMD_LOAD_ALLOCATION)
        begin
            alloc_mem[wr_addr] <= load_amount;
        end
        alloc_q <= alloc_mem[rd_addr];
    end

    // Write and read the request table
    always_ff @(posedge clk)
    begin
        if (load.valid && res_ok && proc_ok && load.command == CMD_LOAD_REQUEST)
        begin
            req_mem[wr_addr] <= load_amount;
        end
        req_q <= req_mem[rd_addr];
    end

    // Write and read the existing-resource vector
    always_ff @(posedge clk)
    begin
        if (load.valid && res_ok && load.command == CMD_LOAD_EXISTING)
        begin
            exist_mem[RW'(load.resource_index)] <= load_amount;
        end
        ext_q <= exist_mem[r_reg];
    end

    // Clamp the active counts to the table sizes
    always_comb
    begin
        if (32'(active_processes) > 32'(MAX_PROCESSES))
        begin
            np = NPW'(MAX_PROCESSES);
        end
        else
        begin
            np = NPW'(active_processes);
        end
        if (32'(active_resource_types) > 32'(MAX_RESOURCE_TYPES))
        begin
            nr = NRW'(MAX_RESOURCE_TYPES);
        end
        else
        begin
            nr = NRW'(active_resource_types);
        end
    end

    assign p_last  = (NPW'(p_reg) + NPW'(1)) == np;
    assign r_last  = (NRW'(r_reg) + NRW'(1)) == nr;
    assign work_rd = work_reg[r_reg];
    assign idle    = (state_reg == ST_IDLE);

    // Flags as they stand once the current process is reported
    always_comb
    begin
        for (int i = 0; i < MAX_PROCESSES; i++)
        begin
            emit_mask[i] = finished_reg[i] | (PW'(i) == p_reg);
        end
    end

    rdd_alu #(
        .WIDTH (WW)
    ) u_alu (
        .a        (alu_a),
        .b        (alu_b),
        .sub      (alu_sub),
        .sum      (alu_sum),
        .negative (alu_neg)
    );

    // Next state and datapath control
    always_comb
    begin
        state_next    = state_reg;
        p_next        = p_reg;
        r_next        = r_reg;
        acc_next      = acc_reg;
        progress_next = progress_reg;
        finished_next = finished_reg;
        work_we       = 1'b0;
        work_next     = alu_sum;
        proc_done     = 1'b0;
        alu_a         = work_rd;
        alu_b         = WW'(alloc_q);
        alu_sub       = 1'b0;
        res_valid     = 1'b0;
        res           = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (load.valid && load.command == CMD_RUN)
                begin
                    finished_next = '1;
                    p_next        = '0;
                    r_next        = '0;
                    progress_next = 1'b0;
                    if (np == '0 || nr == '0)
                    begin
                        state_next = ST_EMPTY;
                    end
                    else
                    begin
                        state_next = ST_SUM_RD;
                    end
                end
            end

            ST_SUM_RD:
            begin
                state_next = ST_SUM_EX;
            end

            // Subtract one allocation from the column total, mark holders
            ST_SUM_EX:
            begin
                alu_a    = (p_reg == '0) ? WW'(ext_q) : acc_reg;
                alu_sub  = 1'b1;
                acc_next = alu_sum;
                if (alloc_q != '0)
                begin
                    finished_next[p_reg] = 1'b0;
                end
                if (p_last)
                begin
                    work_we = 1'b1;
                    p_next  = '0;
                    if (r_last)
                    begin
                        r_next     = '0;
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        r_next     = r_reg + RW'(1);
                        state_next = ST_SUM_RD;
                    end
                end
                else
                begin
                    p_next     = p_reg + PW'(1);
                    state_next = ST_SUM_RD;
                end
            end

            // Skip finished processes
            ST_SCAN:
            begin
                if (finished_reg[p_reg])
                begin
                    proc_done = 1'b1;
                end
                else
                begin
                    r_next     = '0;
                    state_next = ST_CHK_RD;
                end
            end

            ST_CHK_RD:
            begin
                state_next = ST_CHK_EX;
            end

            // Request fits when work minus request stays non-negative
            ST_CHK_EX:
            begin
                alu_b   = WW'(req_q);
                alu_sub = 1'b1;
                if (alu_neg)
                begin
                    proc_done = 1'b1;
                end
                else if (r_last)
                begin
                    r_next     = '0;
                    state_next = ST_ADD_RD;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_CHK_RD;
                end
            end

            ST_ADD_RD:
            begin
                state_next = ST_ADD_EX;
            end

            // Return the allocation of a finishing process to work
            ST_ADD_EX:
            begin
                work_we = 1'b1;
                if (r_last)
                begin
                    finished_next[p_reg] = 1'b1;
                    progress_next        = 1'b1;
                    proc_done            = 1'b1;
                end
                else
                begin
                    r_next     = r_reg + RW'(1);
                    state_next = ST_ADD_RD;
                end
            end

            // Report unfinished processes in ascending order
            ST_EMIT:
            begin
                if (finished_reg[p_reg])
                begin
                    p_next = p_reg + PW'(1);
                end
                else
                begin
                    res_valid              = 1'b1;
                    res.deadlocked_process = PROC_IDX_W'(p_reg);
                    res.is_last            = &emit_mask;
                    if (res_ready)
                    begin
                        finished_next[p_reg] = 1'b1;
                        if (&emit_mask)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            p_next = p_reg + PW'(1);
                        end
                    end
                end
            end

            ST_EMPTY:
            begin
                res_valid           = 1'b1;
                res.is_last         = 1'b1;
                res.none_deadlocked = 1'b1;
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Advance to the next process, or end the sweep
        if (proc_done)
        begin
            r_next = '0;
            if (p_last)
            begin
                p_next = '0;
                if (progress_next)
                begin
                    progress_next = 1'b0;
                    state_next    = ST_SCAN;
                end
                else if (&finished_next)
                begin
                    state_next = ST_EMPTY;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            else
            begin
                p_next     = p_reg + PW'(1);
                state_next = ST_SCAN;
            end
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            p_reg        <= '0;
            r_reg        <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            p_reg        <= p_next;
            r_reg        <= r_next;
            progress_reg <= progress_next;
            finished_reg <= finished_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (work_we)
        begin
            work_reg[r_reg] <= work_next;
        end
    end
endmodule

FILE: rtl/resource_deadlock_detector_top.sv
// Top level: channels, configuration registers and result output register
`timescale 1ns / 1ps

// Resource deadlock detector. Load items (existing count, allocation entry,
// request entry) are taken while the core is idle. A run item keeps the item
// channel stalled until its last result has been handed to the output register.
// All arithmetic goes through one shared adder and each table has one read
// port with a registered read, so every table access takes a read state and
// an execute state. Each sweep scans the processes, checks the requests and
// returns the allocations of finishing processes; up to P+1 sweeps run after
// the column sums over all P*R entries, and reporting is in ascending order.
// P and R are the active process and resource-type counts, clamped to the
// table sizes. Configuration writes are taken every cycle.
module resource_deadlock_detector_top #(
    parameter int MAX_PROCESSES      = rdd_pkg::MAX_PROCESSES_DEF,
    parameter int MAX_RESOURCE_TYPES = rdd_pkg::MAX_RESOURCE_TYPES_DEF,
    parameter int AMOUNT_WIDTH       = rdd_pkg::AMOUNT_WIDTH_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    rdd_item_if.sink     item,
    rdd_result_if.source result,
    rdd_cfg_if.sink      cfg
);
    import rdd_pkg::*;

    logic [ACT_PROC_W-1:0] active_processes_reg;
    logic [ACT_RES_W-1:0]  active_resource_types_reg;
    logic                  core_idle;
    rdd_load_t             load;
    rdd_result_t           core_res;
    logic                  core_res_valid;
    logic                  core_res_ready;
    logic                  out_valid_reg;
    rdd_result_t           out_data_reg;

    // Configuration writes are always taken
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_processes_reg      <= ACT_PROC_RESET;
            active_resource_types_reg <= ACT_RES_RESET;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_ACTIVE_PROCESSES:
                begin
                    active_processes_reg <= ACT_PROC_W'(cfg.data);
                end
                CFG_ACTIVE_RESOURCE_TYPES:
                begin
                    active_resource_types_reg <= ACT_RES_W'(cfg.data);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Items are taken only while the core is idle
    assign item.ready          = core_idle;
    assign load.valid          = item.valid && core_idle;
    assign load.command        = item.command;
    assign load.process_index  = item.process_index;
    assign load.resource_index = item.resource_index;
    assign load.amount         = item.amount;

    rdd_core #(
        .MAX_PROCESSES      (MAX_PROCESSES),
        .MAX_RESOURCE_TYPES (MAX_RESOURCE_TYPES),
        .AMOUNT_WIDTH       (AMOUNT_WIDTH)
    ) u_core (
        .clk                   (clk),
        .rst_n                 (rst_n),
        .active_processes      (active_processes_reg),
        .active_resource_types (active_resource_types_reg),
        .load                  (load),
        .idle                  (core_idle),
        .res                   (core_res),
        .res_valid             (core_res_valid),
        .res_ready             (core_res_ready)
    );

    // Hold one result until its transfer completes
    assign core_res_ready = !out_valid_reg || result.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (core_res_valid && core_res_ready)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (core_res_valid && core_res_ready)
        begin
            out_data_reg <= core_res;
        end
    end

    assign result.valid              = out_valid_reg;
    assign result.deadlocked_process = out_data_reg.deadlocked_process;
    assign result.is_last            = out_data_reg.is_last;
    assign result.none_deadlocked    = out_data_reg.none_deadlocked;
endmodule

FILE: rtl/rdd_checker.sv
// Checker: port-level assertions on the deadlock detector, bound to the top level
`timescale 1ns / 1ps
`include "resource_deadlock_detector_top_defines.svh"

module rdd_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             item_valid,
    input logic                             item_ready,
    input rdd_pkg::rdd_cmd_t                item_command,
    input logic                             result_valid,
    input logic                             result_ready,
    input logic [rdd_pkg::PROC_IDX_W-1:0]   result_deadlocked_process,
    input logic                             result_is_last,
    input logic                             result_none_deadlocked
);
    import rdd_pkg::*;

    // A run transfer blocks the item channel at once
    `RDD_ASSERT_NEXT(a_run_blocks_items, clk, rst_n, item_valid && item_ready && item_command == CMD_RUN, !item_ready, "item channel open right after a run")

    // More results of the run still to come keep the item channel closed
    `RDD_ASSERT_SAME(a_run_not_over, clk, rst_n, result_valid && !result_is_last, !item_ready, "item channel open before the last result")

    // Hold a stalled result
    `RDD_ASSERT_NEXT(a_result_holds, clk, rst_n, result_valid && !result_ready, result_valid && $stable(result_deadlocked_process) && $stable(result_is_last) && $stable(result_none_deadlocked), "stalled result changed")
endmodule

bind resource_deadlock_detector_top rdd_checker u_rdd_checker (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .item_valid                (item.valid),
    .item_ready                (item.ready),
    .item_command              (item.command),
    .result_valid              (result.valid),
    .result_ready              (result.ready),
    .result_deadlocked_process (result.deadlocked_process),
    .result_is_last            (result.is_last),
    .result_none_deadlocked    (result.none_deadlocked)
);
